// ===== src/btum_pkg.sv =====
// Shared types, codes and helpers for the busy-time utilization monitor.
// No dependencies; btum_job_store and the top level import this package.
package btum_pkg;

  // Default number of job types held in the job store
  localparam int JOB_TYPES_DEFAULT = 16;

  // Command codes
  localparam logic [1:0] CMD_BUSY   = 2'd0;
  localparam logic [1:0] CMD_IDLE   = 2'd1;
  localparam logic [1:0] CMD_SET    = 2'd2;
  localparam logic [1:0] CMD_SAMPLE = 2'd3;

  // Metric kinds
  localparam logic [2:0] KIND_EMPTY     = 3'd0;
  localparam logic [2:0] KIND_BUSY_IDLE = 3'd1;
  localparam logic [2:0] KIND_ABSOLUTE  = 3'd2;
  localparam logic [2:0] KIND_INC_TOTAL = 3'd3;
  localparam logic [2:0] KIND_INCREMENT = 3'd4;

  // Configuration register indexes
  localparam logic CFG_JOB_TYPE_MAP = 1'b0;
  localparam logic CFG_REPORT_TOP   = 1'b1;

  // Record kinds
  localparam logic REC_JOB     = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         job_id;
    logic [63:0]        timestamp;
    logic signed [47:0] metric_value;
  } in_t;

  typedef struct packed {
    logic               record_kind;
    logic [3:0]         job_index;
    logic [2:0]         metric_kind;
    logic [31:0]        jobs_delta;
    logic [63:0]        busy_delta;
    logic [63:0]        duration;
    logic               running;
    logic signed [47:0] user_value;
    logic               custom_valid;
    logic               last;
  } out_t;

  // One job store entry: live counters and their values at the last sample
  typedef struct packed {
    logic [63:0] busy;
    logic [31:0] count;
    logic [47:0] custom;
    logic [63:0] s_busy;
    logic [31:0] s_count;
    logic [47:0] s_custom;
  } entry_t;

  // Metric kind of job j: 3-bit field j of the type map
  function automatic logic [2:0] kind_of(input logic [47:0] map, input logic [3:0] j);
    logic [47:0] sh;
    sh = map >> ({2'b00, j} * 6'd3);
    return sh[2:0];
  endfunction

endpackage

// ===== src/btum_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module btum_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/btum_job_store.sv =====
// Per-job-type store: one RAM entry per job type plus a valid bit per entry.
// Depends on btum_pkg and btum_ram; entries never written read as zero.
module btum_job_store #(
  parameter int DEPTH = btum_pkg::JOB_TYPES_DEFAULT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output btum_pkg::entry_t  rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  btum_pkg::entry_t  wr_data
);
  import btum_pkg::*;

  localparam int EW = $bits(entry_t);

  logic [DEPTH-1:0] vld;
  logic             vld_q;
  logic [EW-1:0]    ram_q;

  btum_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // valid bits: set on first write, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
      end
    end
  end

  // unwritten entries read as their reset value
  assign rd_data = vld_q ? entry_t'(ram_q) : '0;

endmodule

// ===== src/busy_time_utilization_monitor_top.sv =====
// Busy-time utilization monitor, top level: event sequencer, worker totals, output register.
// Depends on btum_pkg and btum_job_store.
//
//  channel | handshake            | payload                        | direction
//  --------+----------------------+--------------------------------+----------
//  in      | in_valid / in_ready  | in_data   (btum_pkg::in_t)     | to block
//  out     | out_valid / out_ready| out_data  (btum_pkg::out_t)    | from block
//  cfg     | cfg_valid / cfg_ready| cfg_index (1b), cfg_data (48b) | to block
//
// One request is worked on at a time; in_ready is high only in the idle state.
// Idle: close states (delta, read, write-back) when busy. Busy: read, write-back, after
// the close states when it closes a running interval. Set metric: read, write-back.
// Sample: init, then read, diff with write-back and emit per reported job, then summary.
// Output stalls hold the sequencer in its emit states. Reset is synchronous; the job
// store needs no clearing pass (per-entry valid bits). Config is always ready.
module busy_time_utilization_monitor_top #(
  parameter int JOB_TYPES = btum_pkg::JOB_TYPES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  btum_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output btum_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [47:0]     cfg_data
);
  import btum_pkg::*;

  localparam int JW = (JOB_TYPES > 1) ? $clog2(JOB_TYPES) : 1;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLOSE_D  = 4'd1;
  localparam logic [3:0] S_CLOSE_RD = 4'd2;
  localparam logic [3:0] S_CLOSE_WR = 4'd3;
  localparam logic [3:0] S_BUSY_RD  = 4'd4;
  localparam logic [3:0] S_BUSY_WR  = 4'd5;
  localparam logic [3:0] S_SET_RD   = 4'd6;
  localparam logic [3:0] S_SET_WR   = 4'd7;
  localparam logic [3:0] S_SMP_INIT = 4'd8;
  localparam logic [3:0] S_SJ_RD    = 4'd9;
  localparam logic [3:0] S_SJ_DIFF  = 4'd10;
  localparam logic [3:0] S_SJ_EMIT  = 4'd11;
  localparam logic [3:0] S_SUM_DIFF = 4'd12;
  localparam logic [3:0] S_SUM_EMIT = 4'd13;

  logic [3:0] state, state_next;

  // configuration
  logic [47:0] job_type_map;
  logic [3:0]  report_top;

  // request held for the whole sequence
  logic [1:0]  cmd_q;
  logic [3:0]  jid_q;
  logic [63:0] now_q;
  logic [47:0] val_q;

  // worker state
  logic          busy_flag;
  logic [JW-1:0] current_job;
  logic [63:0]   last_action_time;
  logic [63:0]   checkpoint_time;
  logic [63:0]   total_busy;
  logic [31:0]   total_jobs;
  logic [63:0]   sampled_busy;
  logic [31:0]   sampled_jobs;

  // working registers
  logic [63:0]   d_q;
  logic          run_q;
  logic [63:0]   dt_q;
  logic [JW-1:0] top_q;
  logic [JW-1:0] idx;
  logic [2:0]    kind_q;
  logic          hit_q;
  logic [31:0]   jd_q;
  logic [63:0]   bd_q;
  logic [47:0]   cv_q;
  logic          cvalid_q;
  logic [63:0]   dur_q;

  // job store ports
  logic          st_rd_en;
  logic [JW-1:0] st_rd_addr;
  entry_t        st_rd_data;
  logic          st_wr_en;
  logic [JW-1:0] st_wr_addr;
  entry_t        st_wr_data;

  logic          accept;
  logic          jid_ok;
  logic          out_free;
  logic          out_load;
  out_t          out_next;
  logic [2:0]    idx_kind;
  logic [JW-1:0] top_sel;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign jid_ok    = int'(in_data.job_id) < JOB_TYPES;
  assign out_free  = !out_valid || out_ready;
  assign idx_kind  = kind_of(job_type_map, 4'(idx));
  assign top_sel   = (int'(report_top) > JOB_TYPES - 1) ? JW'(JOB_TYPES - 1) : JW'(report_top);

  btum_job_store #(
    .DEPTH (JOB_TYPES),
    .AW    (JW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data)
  );

  // job store access and entry update, by state
  always_comb begin
    st_rd_en   = 1'b0;
    st_rd_addr = current_job;
    st_wr_en   = 1'b0;
    st_wr_addr = current_job;
    st_wr_data = st_rd_data;
    case (state)
      S_CLOSE_RD: begin
        st_rd_en = 1'b1;
      end
      S_CLOSE_WR: begin
        st_wr_en        = 1'b1;
        st_wr_data.busy = st_rd_data.busy + d_q;
      end
      S_BUSY_RD, S_SET_RD: begin
        st_rd_en   = 1'b1;
        st_rd_addr = JW'(jid_q);
      end
      S_BUSY_WR: begin
        st_wr_en         = 1'b1;
        st_wr_addr       = JW'(jid_q);
        st_wr_data.count = st_rd_data.count + 32'd1;
      end
      S_SET_WR: begin
        st_wr_en   = 1'b1;
        st_wr_addr = JW'(jid_q);
        if (kind_of(job_type_map, jid_q) == KIND_INCREMENT) begin
          st_wr_data.custom = st_rd_data.custom + val_q;
        end else begin
          st_wr_data.custom = val_q;
        end
      end
      S_SJ_RD: begin
        st_rd_en   = 1'b1;
        st_rd_addr = idx;
      end
      S_SJ_DIFF: begin
        // write back the sampled copies the kind calls for
        st_wr_en   = 1'b1;
        st_wr_addr = idx;
        if (idx_kind == KIND_BUSY_IDLE) begin
          st_wr_data.s_count = st_rd_data.count;
          st_wr_data.s_busy  = st_rd_data.busy;
        end else if (idx_kind == KIND_INC_TOTAL || idx_kind == KIND_INCREMENT) begin
          st_wr_data.s_custom = st_rd_data.custom;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_BUSY:   state_next = !jid_ok ? S_IDLE : (busy_flag ? S_CLOSE_D : S_BUSY_RD);
            CMD_IDLE:   state_next = busy_flag ? S_CLOSE_D : S_IDLE;
            CMD_SET:    state_next = jid_ok ? S_SET_RD : S_IDLE;
            CMD_SAMPLE: state_next = S_SMP_INIT;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_CLOSE_D:  state_next = S_CLOSE_RD;
      S_CLOSE_RD: state_next = S_CLOSE_WR;
      S_CLOSE_WR: state_next = (cmd_q == CMD_BUSY) ? S_BUSY_RD : S_IDLE;
      S_BUSY_RD:  state_next = S_BUSY_WR;
      S_BUSY_WR:  state_next = S_IDLE;
      S_SET_RD:   state_next = S_SET_WR;
      S_SET_WR:   state_next = S_IDLE;
      S_SMP_INIT: state_next = S_SJ_RD;
      S_SJ_RD:    state_next = S_SJ_DIFF;
      S_SJ_DIFF:  state_next = S_SJ_EMIT;
      S_SJ_EMIT: begin
        if (out_free) begin
          state_next = (idx == top_q) ? S_SUM_DIFF : S_SJ_RD;
        end
      end
      S_SUM_DIFF: state_next = S_SUM_EMIT;
      S_SUM_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // record assembly
  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    out_next.running = run_q;
    if (state == S_SJ_EMIT) begin
      out_load              = out_free;
      out_next.record_kind  = REC_JOB;
      out_next.job_index    = 4'(idx);
      out_next.metric_kind  = kind_q;
      out_next.jobs_delta   = jd_q;
      out_next.busy_delta   = bd_q + (hit_q ? dt_q : 64'd0);
      out_next.user_value   = $signed(cv_q);
      out_next.custom_valid = cvalid_q;
    end else if (state == S_SUM_EMIT) begin
      out_load             = out_free;
      out_next.record_kind = REC_SUMMARY;
      out_next.jobs_delta  = jd_q;
      out_next.busy_delta  = bd_q + (run_q ? dt_q : 64'd0);
      out_next.duration    = dur_q;
      out_next.last        = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      job_type_map     <= '0;
      report_top       <= '0;
      busy_flag        <= 1'b0;
      current_job      <= '0;
      last_action_time <= '0;
      checkpoint_time  <= '0;
      total_busy       <= '0;
      total_jobs       <= '0;
      sampled_busy     <= '0;
      sampled_jobs     <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      // configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_JOB_TYPE_MAP: job_type_map <= cfg_data;
          CFG_REPORT_TOP:   report_top   <= cfg_data[3:0];
          default: begin
          end
        endcase
      end

      // closing a running interval
      if (state == S_CLOSE_RD) begin
        total_busy <= total_busy + d_q;
        busy_flag  <= 1'b0;
        if (last_action_time < now_q) begin
          last_action_time <= now_q;
        end
      end

      // starting a job
      if (state == S_BUSY_WR) begin
        current_job      <= JW'(jid_q);
        total_jobs       <= total_jobs + 32'd1;
        last_action_time <= now_q;
        busy_flag        <= 1'b1;
      end

      // summary: restart sample window and running interval
      if (state == S_SUM_DIFF) begin
        sampled_busy    <= total_busy;
        sampled_jobs    <= total_jobs;
        checkpoint_time <= now_q;
        if (run_q) begin
          last_action_time <= now_q;
        end
      end

      // output register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= in_data.command;
      jid_q <= in_data.job_id;
      now_q <= in_data.timestamp;
      val_q <= in_data.metric_value;
    end

    if (state == S_CLOSE_D) begin
      d_q <= now_q - last_action_time;
    end

    if (state == S_SMP_INIT) begin
      run_q <= busy_flag;
      dt_q  <= busy_flag ? (now_q - last_action_time) : 64'd0;
      top_q <= top_sel;
      idx   <= '0;
    end

    // per-job deltas from the entry just read
    if (state == S_SJ_DIFF) begin
      kind_q <= idx_kind;
      hit_q  <= run_q && (idx == current_job);
      case (idx_kind)
        KIND_BUSY_IDLE: begin
          jd_q     <= st_rd_data.count - st_rd_data.s_count;
          bd_q     <= st_rd_data.busy - st_rd_data.s_busy;
          cv_q     <= '0;
          cvalid_q <= 1'b0;
        end
        KIND_ABSOLUTE: begin
          jd_q     <= '0;
          bd_q     <= '0;
          cv_q     <= st_rd_data.custom;
          cvalid_q <= 1'b1;
        end
        KIND_INC_TOTAL, KIND_INCREMENT: begin
          jd_q     <= '0;
          bd_q     <= '0;
          cv_q     <= st_rd_data.custom - st_rd_data.s_custom;
          cvalid_q <= 1'b1;
        end
        default: begin
          jd_q     <= '0;
          bd_q     <= '0;
          cv_q     <= '0;
          cvalid_q <= 1'b0;
        end
      endcase
    end

    if (state == S_SJ_EMIT && out_free) begin
      idx <= idx + JW'(1);
    end

    // worker totals for the summary
    if (state == S_SUM_DIFF) begin
      jd_q  <= total_jobs - sampled_jobs;
      bd_q  <= total_busy - sampled_busy;
      dur_q <= now_q - checkpoint_time;
    end

    if (out_load) begin
      out_data <= out_next;
    end
  end

`ifndef ASSERT_OFF
  // the store is never read and written in the same cycle
  a_store_port: assert property (@(posedge clk) disable iff (rst)
    !(st_rd_en && st_wr_en))
    else $error("job store read and write in the same cycle");

  // a per-job record is loaded without the end marker
  a_job_rec: assert property (@(posedge clk) disable iff (rst)
    (state == S_SJ_EMIT && out_free) |=> (out_valid && !out_data.last &&
      out_data.record_kind == REC_JOB))
    else $error("per-job record malformed");

  // the summary ends the sample and returns to idle
  a_sum_rec: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM_EMIT && out_free) |=> (out_valid && out_data.last &&
      state == S_IDLE))
    else $error("summary record did not end the sample");

  // the worker only turns busy by starting a job
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy_flag) |-> ($past(state) == S_BUSY_WR))
    else $error("busy flag set outside job start");

  // a sample never walks past its last reported job
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SJ_DIFF) |-> (idx <= top_q))
    else $error("sample index past its limit");
`endif

endmodule
